>>> rtl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared codes, reset values and beat types of the heightmap slope classifier.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_FLUSH  = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;

  localparam logic [1:0] CFG_SLOPE_COEF     = 2'd0;
  localparam logic [1:0] CFG_ROW_WIDTH      = 2'd1;
  localparam logic [1:0] CFG_ACTIVE_ENTRIES = 2'd2;

  localparam logic [31:0] SLOPE_COEF_RESET     = 32'h0100_0000;
  localparam logic [12:0] ROW_WIDTH_RESET      = 13'd4096;
  localparam logic [4:0]  ACTIVE_ENTRIES_RESET = 5'd0;

  localparam logic [23:0] TAN_MAX = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_FLUSH,
    KIND_LOAD
  } kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] column;
    logic        first_row;
    logic [15:0] height;
    logic [3:0]  entry_index;
    logic [23:0] range_low;
    logic [23:0] range_high;
    logic [31:0] entry_color;
  } in_beat_t;

  typedef struct packed {
    logic [11:0] out_column;
    logic [31:0] right_color;
    logic        right_match;
    logic [31:0] bottom_color;
    logic        bottom_match;
    logic        from_flush;
  } out_beat_t;

  typedef struct packed {
    logic [3:0]  entry_index;
    logic [23:0] range_low;
    logic [23:0] range_high;
    logic [31:0] entry_color;
  } load_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] column;
    logic [15:0] height;
    logic        right_ok;
    logic [15:0] cur;
    logic [15:0] right;
    load_t       load;
  } lb_beat_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] column;
    logic [15:0] right_diff;
    logic [15:0] bottom_diff;
    load_t       load;
  } diff_beat_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] column;
    logic [23:0] right_tan;
    logic [23:0] bottom_tan;
    load_t       load;
  } tan_beat_t;

endpackage

>>> rtl/hsc_stream_if.sv
// ----------------------------------------------------------------------------
// hsc_stream_if
// Valid/ready stream channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface hsc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/heightmap_slope_classifier.sv
// ----------------------------------------------------------------------------
// heightmap_slope_classifier
// Raster-order heightmap slope classifier with row line buffer and range table.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless back pressure stalls it, and returns each
// result through five register stages: input register, line buffer read
// (one write and two reads of a MAX_ROW_WIDTH x 16 memory per cycle), height
// differences, tangent multiply with saturation, and table lookup into the
// output register. Table loads travel down the pipeline and update the table
// at the lookup stage, so every beat sees the table as of its own place in the
// stream. Height samples of the first row, out-of-row columns and opcode 3
// leave the pipeline after the input register and produce nothing. Back
// pressure stalls all stages in place; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module heightmap_slope_classifier #(
  parameter int MAX_ROW_WIDTH = 4096,
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  hsc_stream_if.sink   in_ch,
  hsc_stream_if.source out_ch
);
  import hsc_pkg::*;

  localparam int WCAP = (MAX_ROW_WIDTH > 8191) ? 8191 : MAX_ROW_WIDTH;

  logic [31:0] slope_coef;
  logic [12:0] row_width;
  logic [4:0]  active_entries;
  logic [12:0] row_eff;

  logic      lb_valid;
  logic      lb_ready;
  lb_beat_t  lb_beat;
  logic      tan_valid;
  logic      tan_ready;
  tan_beat_t tan_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_coef     <= SLOPE_COEF_RESET;
      row_width      <= ROW_WIDTH_RESET;
      active_entries <= ACTIVE_ENTRIES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLOPE_COEF:     slope_coef     <= cfg_data;
        CFG_ROW_WIDTH:      row_width      <= cfg_data[12:0];
        CFG_ACTIVE_ENTRIES: active_entries <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (row_width > 13'(WCAP)) begin
      row_eff = 13'(WCAP);
    end else if (row_width == 13'd0) begin
      row_eff = 13'd1;
    end else begin
      row_eff = row_width;
    end
  end

  hsc_line_buffer #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_line_buffer (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .row_eff   (row_eff),
    .out_valid (lb_valid),
    .out_ready (lb_ready),
    .out_beat  (lb_beat)
  );

  hsc_slope u_slope (
    .clk        (clk),
    .rst        (rst),
    .slope_coef (slope_coef),
    .in_valid   (lb_valid),
    .in_ready   (lb_ready),
    .in_beat    (lb_beat),
    .out_valid  (tan_valid),
    .out_ready  (tan_ready),
    .out_beat   (tan_beat)
  );

  hsc_classify #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_classify (
    .clk            (clk),
    .rst            (rst),
    .active_entries (active_entries),
    .in_valid       (tan_valid),
    .in_ready       (tan_ready),
    .in_beat        (tan_beat),
    .out_ch         (out_ch)
  );

endmodule

>>> rtl/hsc_line_buffer.sv
// ----------------------------------------------------------------------------
// hsc_line_buffer
// Input register and row line buffer: reads the stored sample and its right
// neighbour, writes the new sample, drops beats that give no result.
// ----------------------------------------------------------------------------
module hsc_line_buffer #(
  parameter int MAX_ROW_WIDTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  hsc_stream_if.sink       in_ch,
  input  logic [12:0]      row_eff,
  output logic             out_valid,
  input  logic             out_ready,
  output hsc_pkg::lb_beat_t out_beat
);
  import hsc_pkg::*;

  localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;

  logic [15:0] mem [MAX_ROW_WIDTH];

  in_beat_t    s1;
  logic        s1_valid;
  lb_beat_t    s2;
  logic        s2_valid;
  logic [15:0] cur_q;
  logic [15:0] right_q;

  logic        col_ok;
  logic        fwd;
  kind_t       kind;
  logic        s2_free;
  logic        s1_done;
  logic        wr_en;
  logic        take;
  logic [12:0] col_plus;
  logic [AW-1:0] addr_cur;
  logic [AW-1:0] addr_right;

  always_comb begin
    col_plus = {1'b0, s1.column} + 13'd1;
    col_ok   = {1'b0, s1.column} < row_eff;
    case (s1.opcode)
      OP_SAMPLE: begin
        kind = KIND_SAMPLE;
        fwd  = col_ok && !s1.first_row;
      end
      OP_FLUSH: begin
        kind = KIND_FLUSH;
        fwd  = col_ok;
      end
      OP_LOAD: begin
        kind = KIND_LOAD;
        fwd  = 1'b1;
      end
      default: begin
        kind = KIND_SAMPLE;
        fwd  = 1'b0;
      end
    endcase
    s2_free    = !s2_valid || out_ready;
    s1_done    = s1_valid && (!fwd || s2_free);
    wr_en      = s1_done && (s1.opcode == OP_SAMPLE) && col_ok;
    take       = in_ch.valid && in_ch.ready;
    addr_cur   = AW'(s1.column);
    addr_right = AW'(col_plus);
  end

  assign in_ch.ready = !s1_valid || s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s1_done && fwd) begin
        s2_valid <= 1'b1;
      end else if (out_ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1 <= in_ch.data;
    end
    if (wr_en) begin
      mem[addr_cur] <= s1.height;
    end
    if (s1_done && fwd) begin
      cur_q                <= mem[addr_cur];
      right_q              <= mem[addr_right];
      s2.kind              <= kind;
      s2.column            <= s1.column;
      s2.height            <= s1.height;
      s2.right_ok          <= col_plus < row_eff;
      s2.cur               <= '0;
      s2.right             <= '0;
      s2.load.entry_index  <= s1.entry_index;
      s2.load.range_low    <= s1.range_low;
      s2.load.range_high   <= s1.range_high;
      s2.load.entry_color  <= s1.entry_color;
    end
  end

  always_comb begin
    out_beat       = s2;
    out_beat.cur   = cur_q;
    out_beat.right = right_q;
  end

  assign out_valid = s2_valid;

endmodule

>>> rtl/hsc_slope.sv
// ----------------------------------------------------------------------------
// hsc_slope
// Absolute height differences, then scaling to saturated Q8.16 tangents.
// ----------------------------------------------------------------------------
module hsc_slope (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         slope_coef,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsc_pkg::lb_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output hsc_pkg::tan_beat_t  out_beat
);
  import hsc_pkg::*;

  diff_beat_t s3;
  logic       s3_valid;
  tan_beat_t  s4;
  logic       s4_valid;

  logic        s4_free;
  logic        s3_free;
  logic [15:0] right_diff;
  logic [15:0] bottom_diff;
  logic [47:0] right_prod;
  logic [47:0] bottom_prod;

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [23:0] sat_tan(input logic [47:0] p);
    return (p[47:32] != 16'd0) ? TAN_MAX : p[31:8];
  endfunction

  always_comb begin
    s4_free     = !s4_valid || out_ready;
    s3_free     = !s3_valid || s4_free;
    right_diff  = in_beat.right_ok ? abs_diff(in_beat.cur, in_beat.right) : 16'd0;
    bottom_diff = (in_beat.kind == KIND_SAMPLE) ? abs_diff(in_beat.cur, in_beat.height) : 16'd0;
    right_prod  = {32'd0, s3.right_diff} * {16'd0, slope_coef};
    bottom_prod = {32'd0, s3.bottom_diff} * {16'd0, slope_coef};
  end

  assign in_ready = s3_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s3_free) begin
        s3_valid <= in_valid;
      end
      if (s4_free) begin
        s4_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s3_free) begin
      s3.kind        <= in_beat.kind;
      s3.column      <= in_beat.column;
      s3.right_diff  <= right_diff;
      s3.bottom_diff <= bottom_diff;
      s3.load        <= in_beat.load;
    end
    if (s3_valid && s4_free) begin
      s4.kind       <= s3.kind;
      s4.column     <= s3.column;
      s4.right_tan  <= sat_tan(right_prod);
      s4.bottom_tan <= sat_tan(bottom_prod);
      s4.load       <= s3.load;
    end
  end

  assign out_valid = s4_valid;
  assign out_beat  = s4;

endmodule

>>> rtl/hsc_classify.sv
// ----------------------------------------------------------------------------
// hsc_classify
// Slope range table, first-match lookup of both tangents and output register.
// ----------------------------------------------------------------------------
module hsc_classify #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [4:0]          active_entries,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsc_pkg::tan_beat_t  in_beat,
  hsc_stream_if.source        out_ch
);
  import hsc_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [23:0] lo_tbl    [TABLE_ENTRIES];
  logic [23:0] hi_tbl    [TABLE_ENTRIES];
  logic [31:0] color_tbl [TABLE_ENTRIES];

  out_beat_t out_q;
  logic      out_valid;

  logic        advance;
  logic        tbl_we;
  logic [32:0] right_hit;
  logic [32:0] bottom_hit;
  out_beat_t   result;

  function automatic logic [32:0] lookup(input logic [23:0] tan);
    logic        below;
    logic        hit;
    logic [31:0] color;
    below = 1'b0;
    color = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit   = (32'(active_entries) > 32'(i)) && (tan >= lo_tbl[i]) && (tan < hi_tbl[i]);
      color = color | ({32{hit && !below}} & color_tbl[i]);
      below = below | hit;
    end
    return {below, color};
  endfunction

  always_comb begin
    in_ready   = !out_valid || out_ch.ready;
    advance    = in_valid && in_ready;
    tbl_we     = advance && (in_beat.kind == KIND_LOAD) &&
                 (32'(in_beat.load.entry_index) < 32'(TABLE_ENTRIES));
    right_hit  = lookup(in_beat.right_tan);
    bottom_hit = lookup(in_beat.bottom_tan);
    result.out_column   = in_beat.column;
    result.right_color  = right_hit[31:0];
    result.right_match  = right_hit[32];
    result.bottom_color = bottom_hit[32] ? bottom_hit[31:0] : right_hit[31:0];
    result.bottom_match = bottom_hit[32];
    result.from_flush   = (in_beat.kind == KIND_FLUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (in_beat.kind != KIND_LOAD)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (in_beat.kind != KIND_LOAD)) begin
      out_q <= result;
    end
    if (tbl_we) begin
      lo_tbl[IW'(in_beat.load.entry_index)]    <= in_beat.load.range_low;
      hi_tbl[IW'(in_beat.load.entry_index)]    <= in_beat.load.range_high;
      color_tbl[IW'(in_beat.load.entry_index)] <= in_beat.load.entry_color;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_q;

endmodule
